// ----- design/sweep_prune_pair_finder_top_macros.svh -----
// assertion macros for the pair finder top level
// no dependencies
`ifndef SWEEP_PRUNE_PAIR_FINDER_TOP_MACROS_SVH
`define SWEEP_PRUNE_PAIR_FINDER_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SPF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define SPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/spf_pkg.sv -----
// shared types and constants of the sweep and prune pair finder
// no dependencies
package spf_pkg;
  localparam int MAX_BOXES   = 16;
  localparam int LAYER_COUNT = 8;
  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int TAG_W = 12;
  localparam int BOX_W = 6 * 32 + TAG_W;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic             clear;      // empty the store
    logic             cap_in;     // capture input word
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             cap_ref;    // registered read data is the scanned box
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_sel_in;  // write the new box, else shifted entry
    logic             cnt_inc;
  } spf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             key_gt;     // read entry min x above new key
    logic             in_range;   // read entry min x within scanned max x
    logic             hit;        // read entry pairs with scanned box
    logic [7:0]       ref_id;
    logic [7:0]       cand_id;
  } spf_sts_t;
endpackage

// ----- design/spf_ram.sv -----
// generic single write, single read memory with registered read
// no dependencies
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ----- design/spf_datapath.sv -----
// box store, captured input box, comparators and layer test
// depends on spf_pkg and spf_ram
module spf_datapath import spf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  spf_cmd_t    cmd,
  input  logic [63:0] mask,
  input  logic [7:0]  in_box_id,
  input  logic [31:0] in_min_x,
  input  logic [31:0] in_max_x,
  input  logic [31:0] in_min_y,
  input  logic [31:0] in_max_y,
  input  logic [31:0] in_min_z,
  input  logic [31:0] in_max_z,
  input  logic [2:0]  in_layer,
  input  logic        in_is_static,
  output spf_sts_t    sts
);
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BOX_W-1:0] new_r, ref_r, rd_data, wr_data;
  logic [2:0]       lay;

  // entries: tag, min x, max x, min y, max y, min z, max z (biased keys)
  always_comb begin
    lay = (32'(in_layer) >= 32'(LAYER_COUNT)) ? 3'(LAYER_COUNT - 1) : in_layer;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in)
      new_r <= {in_is_static, lay, in_box_id,
                in_min_x ^ 32'h8000_0000, in_max_x ^ 32'h8000_0000,
                in_min_y ^ 32'h8000_0000, in_max_y ^ 32'h8000_0000,
                in_min_z ^ 32'h8000_0000, in_max_z ^ 32'h8000_0000};
    if (cmd.cap_ref) ref_r <= rd_data;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) count_nxt = '0;
    else if (cmd.cnt_inc) count_nxt = count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  assign wr_data = cmd.wr_sel_in ? new_r : rd_data;

  spf_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_store (
    .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_data),
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_data)
  );

  logic [31:0] c_mnx, c_mny, c_mxy, c_mnz, c_mxz, r_mxx, r_mny, r_mxy, r_mnz, r_mxz;
  logic [TAG_W-1:0] c_tag, r_tag;
  logic lay_ok;
  assign {c_tag, c_mnx} = rd_data[BOX_W-1:160];
  assign c_mny = rd_data[127:96];
  assign c_mxy = rd_data[95:64];
  assign c_mnz = rd_data[63:32];
  assign c_mxz = rd_data[31:0];
  assign r_tag = ref_r[BOX_W-1:192];
  assign r_mxx = ref_r[159:128];
  assign r_mny = ref_r[127:96];
  assign r_mxy = ref_r[95:64];
  assign r_mnz = ref_r[63:32];
  assign r_mxz = ref_r[31:0];
  assign lay_ok = (r_tag[10:8] == c_tag[10:8]) || mask[{r_tag[10:8], c_tag[10:8]}];

  always_comb begin
    sts.count    = count_r;
    sts.key_gt   = c_mnx > new_r[191:160];
    sts.in_range = c_mnx <= r_mxx;
    sts.hit      = !(r_mxy < c_mny) && !(c_mxy < r_mny) &&
                   !(r_mxz < c_mnz) && !(c_mxz < r_mnz) &&
                   !(r_tag[11] && c_tag[11]) && lay_ok;
    sts.ref_id   = r_tag[7:0];
    sts.cand_id  = c_tag[7:0];
  end
endmodule

// ----- design/spf_ctrl.sv -----
// sequencer for insertion shifting and pair scanning, result register
// depends on spf_pkg
module spf_ctrl import spf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_pair_valid,
  output logic [7:0]  out_first_id,
  output logic [7:0]  out_second_id,
  output logic        out_last,
  output spf_cmd_t    cmd,
  input  spf_sts_t    sts
);
  localparam logic [2:0] S_IDLE = 3'd0, S_LRD = 3'd1, S_LCMP = 3'd2,
                         S_SREF = 3'd3, S_SCMP = 3'd4, S_EMIT = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;        // load: hole position, scan: candidate
  logic             found_r, found_nxt;    // scan holds a staged pair
  logic             ov_r, ov_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             pv_r, pv_nxt, last_r, last_nxt;
  logic [7:0]       a_r, a_nxt, b_r, b_nxt;
  logic [7:0]       ha_r, ha_nxt, hb_r, hb_nxt;  // staged pair ids
  logic             acc, fire;

  assign acc  = in_valid && in_ready;
  assign fire = !ov_r || out_ready;      // result slot free this cycle
  assign in_ready = (state_r == S_IDLE) && !ov_r;

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_pair_valid = pv_r;
  assign out_first_id = a_r;
  assign out_second_id = b_r;
  assign out_last = last_r;

  always_comb begin
    state_nxt = state_r; pos_nxt = pos_r; found_nxt = found_r;
    ov_nxt = ov_r && !out_ready;
    st_nxt = st_r; pv_nxt = pv_r; last_nxt = last_r; a_nxt = a_r; b_nxt = b_r;
    ha_nxt = ha_r; hb_nxt = hb_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.cap_in = 1'b1;
          st_nxt = ST_OK; pv_nxt = 1'b0; last_nxt = 1'b1; a_nxt = '0; b_nxt = '0;
          case (in_opcode)
            OP_CLEAR: begin cmd.clear = 1'b1; ov_nxt = 1'b1; end
            OP_LOAD: begin
              if (sts.count == CNT_W'(MAX_BOXES)) begin
                st_nxt = ST_FULL; ov_nxt = 1'b1;
              end else if (sts.count == '0) begin
                state_nxt = S_LCMP; pos_nxt = '0;
              end else begin
                pos_nxt = sts.count; state_nxt = S_LRD;
                cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(sts.count - 1'b1);
              end
            end
            OP_SCAN: begin
              if (CNT_W'(in_rank) >= sts.count || 7'(in_rank) >= 7'(sts.count)) begin
                st_nxt = ST_RANK; ov_nxt = 1'b1;
              end else begin
                cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(in_rank);
                pos_nxt = CNT_W'(in_rank) + 1'b1; found_nxt = 1'b0;
                state_nxt = S_SREF;
              end
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_LRD: state_nxt = S_LCMP;   // wait for read data of entry pos-1
      S_LCMP: begin
        // the entry at pos-1 is on rd_data when pos > 0
        if (pos_r != '0 && sts.key_gt) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = IDX_W'(pos_r);
          pos_nxt = pos_r - 1'b1;
          if (pos_r != CNT_W'(1)) begin
            cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(pos_r - 2'd2);
            state_nxt = S_LRD;
          end
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_sel_in = 1'b1; cmd.wr_addr = IDX_W'(pos_r);
          cmd.cnt_inc = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_SREF: begin
        cmd.cap_ref = 1'b1;
        if (pos_r >= sts.count) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(pos_r);
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!sts.in_range) begin
          state_nxt = S_EMIT;
        end else if (!(sts.hit && found_r && !fire)) begin
          // a new hit pushes the staged pair out as a non-final word
          if (sts.hit) begin
            if (found_r) begin
              st_nxt = ST_OK; pv_nxt = 1'b1; a_nxt = ha_r; b_nxt = hb_r;
              last_nxt = 1'b0; ov_nxt = 1'b1;
            end
            found_nxt = 1'b1; ha_nxt = sts.ref_id; hb_nxt = sts.cand_id;
          end
          pos_nxt = pos_r + 1'b1;
          if (pos_r + 1'b1 >= sts.count) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(pos_r + 1'b1);
          end
        end
        // otherwise hold until the earlier pair leaves
      end
      S_EMIT: begin
        // staged pair, or the empty word, goes out as the final word
        if (fire) begin
          st_nxt = ST_OK; pv_nxt = found_r; last_nxt = 1'b1; ov_nxt = 1'b1;
          a_nxt = found_r ? ha_r : 8'd0;
          b_nxt = found_r ? hb_r : 8'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; found_r <= 1'b0;
    end else begin
      state_r <= state_nxt; found_r <= found_nxt; ov_r <= ov_nxt;
    end
    pos_r <= pos_nxt; st_r <= st_nxt; pv_r <= pv_nxt; last_r <= last_nxt;
    a_r <= a_nxt; b_r <= b_nxt; ha_r <= ha_nxt; hb_r <= hb_nxt;
  end
endmodule

// ----- design/sweep_prune_pair_finder_top.sv -----
// sweep and prune pair finder top level: config register, controller, datapath
// depends on spf_pkg, spf_ctrl, spf_datapath and the macros header
//
// channel | dir | handshake                  | payload
// in      | in  | in_valid / in_ready        | opcode, box, layer, static, rank
// out     | out | out_valid / out_ready      | status, pair, ids, last
// cfg     | in  | cfg_valid / cfg_ready      | layer pair mask
//
// clear, drop and rejected scan: a single result word, no new word taken while it waits
// load: walks down from the top entry, moving each entry with a min x above the new key
// up one slot via the single read port of the box store, then writes the new box there
// scan: accept and reference read, one entry compared per cycle unless stalled, then the final word
// reset clears count, state and the mask; the store holds garbage until loaded
// a stalled result word holds the walk in place when another pair needs the slot
`include "sweep_prune_pair_finder_top_macros.svh"
module sweep_prune_pair_finder_top import spf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_box_id,
  input  logic [31:0] in_min_x,
  input  logic [31:0] in_max_x,
  input  logic [31:0] in_min_y,
  input  logic [31:0] in_max_y,
  input  logic [31:0] in_min_z,
  input  logic [31:0] in_max_z,
  input  logic [2:0]  in_layer,
  input  logic        in_is_static,
  input  logic [5:0]  in_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_pair_valid,
  output logic [7:0]  out_first_id,
  output logic [7:0]  out_second_id,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  logic [63:0] mask_r;
  spf_cmd_t cmd;
  spf_sts_t sts;

  // mask register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= '0;
    else if (cfg_valid) mask_r <= cfg_data;
  end

  spf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_rank(in_rank), .out_valid(out_valid),
    .out_ready(out_ready), .out_status(out_status),
    .out_pair_valid(out_pair_valid), .out_first_id(out_first_id),
    .out_second_id(out_second_id), .out_last(out_last), .cmd(cmd), .sts(sts)
  );

  spf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .mask(mask_r), .in_box_id(in_box_id),
    .in_min_x(in_min_x), .in_max_x(in_max_x), .in_min_y(in_min_y),
    .in_max_y(in_max_y), .in_min_z(in_min_z), .in_max_z(in_max_z),
    .in_layer(in_layer), .in_is_static(in_is_static), .sts(sts)
  );

  // store never overfills
  `SPF_ASSERT_IMPL(a_count_max, 1'b1, sts.count <= CNT_W'(MAX_BOXES), "box count overflow")
  // a pair word always carries status ok
  `SPF_ASSERT_IMPL(a_pair_ok, out_valid && out_pair_valid, out_status == ST_OK, "pair with bad status")
  // no new word accepted while a result waits
  `SPF_ASSERT_IMPL(a_no_overlap, out_valid && !out_ready, !in_ready, "input taken over waiting result")
endmodule

// ----- test/sweep_prune_pair_finder_top_tb.sv -----
// self-checking testbench for the sweep and prune pair finder top level
// depends on spf_pkg and sweep_prune_pair_finder_top; a class tracks the box store
// and checks every result word in order
module sweep_prune_pair_finder_top_tb;
  import spf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_GAP   = 48;   // worst load walk plus margin
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         id;
    logic signed [31:0] mnx, mxx, mny, mxy, mnz, mxz;
    logic [2:0]         layer;
    logic               stat;
    logic [5:0]         rank;
  } box_word_t;

  typedef struct {
    logic [1:0] status;
    logic       pv;
    logic [7:0] fid;
    logic [7:0] sid;
    logic       last;
  } pair_word_t;

  // mirror of the box store plus the queue of pair words still owed
  class spf_scoreboard;
    logic [63:0]        mask;
    int                 count;
    logic signed [31:0] mnx[MAX_BOXES], mxx[MAX_BOXES], mny[MAX_BOXES];
    logic signed [31:0] mxy[MAX_BOXES], mnz[MAX_BOXES], mxz[MAX_BOXES];
    logic [7:0]         tid[MAX_BOXES];
    logic [2:0]         tly[MAX_BOXES];
    logic               tst[MAX_BOXES];
    pair_word_t         owed[$];
    int                 errors;

    function new();
      mask = '0;
      count = 0;
      errors = 0;
    endfunction

    function void owe(logic [1:0] s, logic pv, logic [7:0] a, logic [7:0] b, logic l);
      pair_word_t p;
      p.status = s; p.pv = pv; p.fid = a; p.sid = b; p.last = l;
      owed = {owed, p};
    endfunction

    function bit layers_ok(logic [2:0] a, logic [2:0] b);
      return (a == b) || mask[{a, b}];
    endfunction

    function void note_word(box_word_t w);
      int pos, n;
      if (w.op == OP_CLEAR) begin
        count = 0;
        owe(ST_OK, 1'b0, 8'd0, 8'd0, 1'b1);
      end else if (w.op == OP_LOAD) begin
        if (count >= MAX_BOXES) begin
          owe(ST_FULL, 1'b0, 8'd0, 8'd0, 1'b1);
        end else begin
          pos = count;
          while (pos > 0 && mnx[pos-1] > w.mnx) pos--;
          for (int i = count; i > pos; i--) begin
            mnx[i] = mnx[i-1]; mxx[i] = mxx[i-1]; mny[i] = mny[i-1];
            mxy[i] = mxy[i-1]; mnz[i] = mnz[i-1]; mxz[i] = mxz[i-1];
            tid[i] = tid[i-1]; tly[i] = tly[i-1]; tst[i] = tst[i-1];
          end
          mnx[pos] = w.mnx; mxx[pos] = w.mxx; mny[pos] = w.mny;
          mxy[pos] = w.mxy; mnz[pos] = w.mnz; mxz[pos] = w.mxz;
          tid[pos] = w.id; tly[pos] = w.layer; tst[pos] = w.stat;
          count++;
          owe(ST_OK, 1'b0, 8'd0, 8'd0, 1'b1);
        end
      end else if (w.op == OP_SCAN) begin
        if (w.rank >= count) begin
          owe(ST_RANK, 1'b0, 8'd0, 8'd0, 1'b1);
        end else begin
          n = 0;
          for (int j = w.rank + 1; j < count && mnx[j] <= mxx[w.rank]; j++) begin
            if (mxy[w.rank] < mny[j] || mxy[j] < mny[w.rank]) continue;
            if (mxz[w.rank] < mnz[j] || mxz[j] < mnz[w.rank]) continue;
            if (tst[w.rank] && tst[j]) continue;
            if (!layers_ok(tly[w.rank], tly[j])) continue;
            owe(ST_OK, 1'b1, tid[w.rank], tid[j], 1'b0);
            n++;
          end
          if (n == 0) owe(ST_OK, 1'b0, 8'd0, 8'd0, 1'b1);
          else owed[owed.size()-1].last = 1'b1;
        end
      end else begin
        owe(ST_OK, 1'b0, 8'd0, 8'd0, 1'b1);   // unused opcode
      end
    endfunction

    function void check_word(pair_word_t act);
      pair_word_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected word status=%0d pair=%0b ids=%0d/%0d last=%0b",
                 $time, act.status, act.pv, act.fid, act.sid, act.last);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (e.status !== act.status) begin
        $display("%0t: status exp %0d act %0d", $time, e.status, act.status); errors++;
      end
      if (e.pv !== act.pv) begin
        $display("%0t: pair_valid exp %0b act %0b", $time, e.pv, act.pv); errors++;
      end
      if (e.fid !== act.fid) begin
        $display("%0t: first_id exp %0d act %0d", $time, e.fid, act.fid); errors++;
      end
      if (e.sid !== act.sid) begin
        $display("%0t: second_id exp %0d act %0d", $time, e.sid, act.sid); errors++;
      end
      if (e.last !== act.last) begin
        $display("%0t: last exp %0b act %0b", $time, e.last, act.last); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_opcode;
  logic [7:0]  in_box_id;
  logic [31:0] in_min_x, in_max_x, in_min_y, in_max_y, in_min_z, in_max_z;
  logic [2:0]  in_layer;
  logic        in_is_static;
  logic [5:0]  in_rank;
  logic        out_valid, out_ready;
  logic [1:0]  out_status;
  logic        out_pair_valid;
  logic [7:0]  out_first_id, out_second_id;
  logic        out_last;
  logic        cfg_valid, cfg_ready;
  logic [63:0] cfg_data;

  sweep_prune_pair_finder_top dut (.*);

  spf_scoreboard sb = new();
  int snd_idle = 0;   // percent of cycles the sender holds back
  int rcv_idle = 0;   // percent of cycles the receiver holds back
  int rcv_hold = 0;   // forced back-pressure cycles still to run
  int cycles   = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: take words, check them, then pick next ready
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_word('{out_status, out_pair_valid, out_first_id, out_second_id, out_last});
      if (rcv_hold > 0) begin
        rcv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // random word with every field filled, so ignored fields toggle too
  function automatic box_word_t noise_word();
    box_word_t w;
    w.op = 2'($urandom); w.id = 8'($urandom); w.layer = 3'($urandom);
    w.stat = 1'($urandom); w.rank = 6'($urandom);
    w.mnx = $urandom; w.mxx = $urandom; w.mny = $urandom;
    w.mxy = $urandom; w.mnz = $urandom; w.mxz = $urandom;
    return w;
  endfunction

  // small clustered boxes so sweeps overlap often; wide random extents now and then
  function automatic box_word_t rand_box();
    box_word_t w;
    int lo;
    w = noise_word();
    w.op = OP_LOAD;
    w.stat = ($urandom_range(99) < 30);
    if ($urandom_range(9) != 0) begin
      lo = $urandom_range(40) - 20;
      w.mnx = lo <<< 14; w.mxx = (lo + $urandom_range(12)) <<< 14;
      lo = $urandom_range(16) - 8;
      w.mny = lo <<< 14; w.mxy = (lo + $urandom_range(10)) <<< 14;
      lo = $urandom_range(16) - 8;
      w.mnz = lo <<< 14; w.mxz = (lo + $urandom_range(10)) <<< 14;
    end
    return w;
  endfunction

  function automatic box_word_t op_word(logic [1:0] op, logic [5:0] rank);
    box_word_t w;
    w = noise_word();
    w.op = op; w.rank = rank;
    return w;
  endfunction

  // call at a rising edge; returns at the edge that accepts the word
  task automatic send(box_word_t w);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_opcode <= w.op; in_box_id <= w.id; in_layer <= w.layer;
    in_is_static <= w.stat; in_rank <= w.rank;
    in_min_x <= w.mnx; in_max_x <= w.mxx; in_min_y <= w.mny;
    in_max_y <= w.mxy; in_min_z <= w.mnz; in_max_z <= w.mxz;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
  endtask

  // idle the input, then wait until every owed word has been seen
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_mask(logic [63:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mask = v;
  endtask

  // clear, fill with n boxes, then scan random ranks with a little noise mixed in
  task automatic scene(int n);
    send(op_word(OP_CLEAR, 6'd0));
    for (int i = 0; i < n; i++) send(rand_box());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send(noise_word());
      else send(op_word(OP_SCAN, 6'($urandom_range(sb.count + 1))));
    end
  endtask

  // roughly the given number of words, counting the overflow scene
  task automatic run_phase(int items);
    int k, n;
    k = 2 * (MAX_BOXES + 2) + 1;
    scene(MAX_BOXES + 2);   // overflow the store once per phase
    while (k < items) begin
      n = $urandom_range(1, 8);
      scene(n);
      k += 2 * n + 1;
    end
  endtask

  initial begin
    box_word_t w;
    rst_n = 1'b0;
    in_valid = 1'b0; in_opcode = '0; in_box_id = '0; in_layer = '0;
    in_is_static = 1'b0; in_rank = '0;
    in_min_x = '0; in_max_x = '0; in_min_y = '0; in_max_y = '0;
    in_min_z = '0; in_max_z = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty scans, unused opcode, extreme extents, equal keys, statics
    send(op_word(OP_CLEAR, 6'd0));
    send(op_word(OP_SCAN, 6'd0));
    send(op_word(OP_UNUSED, 6'd0));
    w = rand_box();
    w.id = 8'hFF; w.layer = 3'd7; w.stat = 1'b1;
    w.mnx = 32'sh8000_0000; w.mxx = 32'sh7FFF_FFFF;
    w.mny = 32'sh8000_0000; w.mxy = 32'sh7FFF_FFFF;
    w.mnz = 32'sh8000_0000; w.mxz = 32'sh7FFF_FFFF;
    send(w);
    w.id = 8'h00; w.layer = 3'd0; w.stat = 1'b0;
    w.mnx = 32'sh7FFF_FFFF; w.mxy = 32'sh8000_0000; w.mny = 32'sh8000_0000;
    send(w);
    w.id = 8'h11; w.mnx = 32'sh0; w.mxx = 32'sh0001_0000;
    w.mny = 32'sh0; w.mxy = 32'sh0; w.mnz = 32'sh0; w.mxz = 32'sh0;
    send(w);
    w.id = 8'h12; w.layer = 3'd0; w.stat = 1'b1;   // same key, arrives after
    send(w);
    w.id = 8'h13; w.layer = 3'd5; w.stat = 1'b1;   // static pair with previous
    w.mnx = 32'sh0001_0000;                       // touches max x exactly
    send(w);
    for (int r = 0; r < 5; r++) send(op_word(OP_SCAN, 6'(r)));
    send(op_word(OP_SCAN, 6'd63));

    // every layer pair allowed, rescan the same store
    write_mask('1);
    for (int r = 0; r < 5; r++) send(op_word(OP_SCAN, 6'(r)));

    // random phases; mask and idle pattern change between them
    write_mask({$urandom, $urandom});
    snd_idle = 27; rcv_idle = 81;
    run_phase(45);

    write_mask('0);
    snd_idle = 81; rcv_idle = 27;
    run_phase(45);

    write_mask({$urandom, $urandom});
    snd_idle = 0; rcv_idle = 0;
    run_phase(45);

    // long receiver hold-off while words keep coming, so the input stalls
    rcv_hold = 400;
    scene(6);
    drain();

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- sweep_prune_pair_finder_top.f -----
+incdir+design
design/spf_pkg.sv
design/spf_ram.sv
design/spf_datapath.sv
design/spf_ctrl.sv
design/sweep_prune_pair_finder_top.sv
test/sweep_prune_pair_finder_top_tb.sv
